>>> sv/fec_pkg.sv
// Shared widths, reset values and register codes for the feedback echo comb.
`default_nettype none

package fec_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int DAC_W      = 12;
    localparam int GAIN_W     = 10;
    localparam int DLEN_W     = 11;
    localparam int STORE_W    = 16;
    localparam int FRAC_W     = 10;
    localparam int PROD_W     = GAIN_W + 1 + STORE_W;
    localparam int FB_W       = PROD_W - FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd502;
    localparam logic [DLEN_W-1:0] DLEN_RESET = 11'd1010;

    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd1;

endpackage

`default_nettype wire

>>> sv/fec_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/fec_ctrl.sv
// Configuration registers, ring length clamp, write position and store clearing pass.
`default_nettype none

module fec_ctrl
    import fec_pkg::*;
#(
    parameter int MAX_DELAY = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                         accept,
    output logic      [GAIN_W-1:0]            gain,
    output logic      [$clog2(MAX_DELAY)-1:0] wr_pos,
    output logic      [$clog2(MAX_DELAY)-1:0] rd_addr,
    output logic                              clr_busy,
    output logic      [$clog2(MAX_DELAY)-1:0] clr_addr
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = ($clog2(MAX_DELAY + 1) > DLEN_W) ? $clog2(MAX_DELAY + 1) : DLEN_W;
    localparam logic [LW-1:0] LEN_MIN = LW'(2);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_DELAY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);

    logic [GAIN_W-1:0] gain_reg;
    logic [DLEN_W-1:0] dlen_reg;
    logic [AW-1:0]     wp_reg;
    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic [LW-1:0] dlen_ext;
    logic [LW-1:0] len;
    logic [AW-1:0] pos;
    logic [LW-1:0] inc;
    logic [AW-1:0] wp_next;

    always_comb
    begin
        dlen_ext = LW'(dlen_reg);
        if (dlen_ext < LEN_MIN)
        begin
            len = LEN_MIN;
        end
        else if (dlen_ext > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        else
        begin
            len = dlen_ext;
        end
        pos = (LW'(wp_reg) >= len) ? '0 : wp_reg;
        inc = LW'(pos) + LW'(1);
        wp_next = (inc >= len) ? '0 : inc[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            dlen_reg     <= DLEN_RESET;
            wp_reg       <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FEEDBACK_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_DELAY_LENGTH:  dlen_reg <= cfg_data[DLEN_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                wp_reg <= wp_next;
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign gain     = gain_reg;
    assign wr_pos   = pos;
    assign rd_addr  = wp_next;
    assign clr_busy = clr_busy_reg;
    assign clr_addr = clr_addr_reg;

endmodule

`default_nettype wire

>>> sv/fec_pipe.sv
// Three-stage echo datapath: store read, feedback multiply, sum with store write-back and output.
`default_nettype none

module fec_pipe
    import fec_pkg::*;
#(
    parameter int MAX_DELAY = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [SAMPLE_W-1:0]          adc_sample,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [DAC_W-1:0]             dac_word,
    input  wire logic [GAIN_W-1:0]            gain,
    input  wire logic [$clog2(MAX_DELAY)-1:0] wr_pos,
    input  wire logic [$clog2(MAX_DELAY)-1:0] rd_addr,
    input  wire logic                         clr_busy,
    input  wire logic [$clog2(MAX_DELAY)-1:0] clr_addr,
    output logic                              accept
);

    localparam int AW = $clog2(MAX_DELAY);

    logic                       v1_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic [AW-1:0]              wa1_reg;

    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic [AW-1:0]              wa2_reg;
    logic signed [PROD_W-1:0]   prod2_reg;

    logic                       v3_reg;
    logic [DAC_W-1:0]           dac_reg;

    logic                       ready1;
    logic                       ready2;
    logic                       ready3;
    logic                       load2;
    logic                       load3;
    logic                       hazard;
    logic [STORE_W-1:0]         ram_rdata;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_biased;
    logic signed [FB_W-1:0]     fb;
    logic [FB_W-1:0]            sum_wide;
    logic [STORE_W-1:0]         sum;
    logic [DAC_W-2:0]           dac_high;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [STORE_W-1:0]         ram_wdata;

    always_comb
    begin
        ready3   = !v3_reg || out_ready;
        load3    = v2_reg && ready3;
        ready2   = !v2_reg || ready3;
        load2    = v1_reg && ready2;
        ready1   = !v1_reg || ready2;
        hazard   = (v1_reg && (wa1_reg == rd_addr)) || (v2_reg && (wa2_reg == rd_addr));
        in_ready = ready1 && !clr_busy && !hazard;
        accept   = in_valid && in_ready;
    end

    always_comb
    begin
        prod_next   = $signed({1'b0, gain}) * $signed(ram_rdata);
        prod_biased = prod2_reg + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod2_reg[PROD_W-1]}}});
        fb          = prod_biased[PROD_W-1:FRAC_W];
        sum_wide    = FB_W'({{(FB_W-SAMPLE_W){x2_reg[SAMPLE_W-1]}}, x2_reg}) + FB_W'(fb);
        sum         = sum_wide[STORE_W-1:0];
        dac_high    = sum[DAC_W-2:0] + (DAC_W-1)'(512);
    end

    always_comb
    begin
        if (clr_busy)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = load3;
            ram_waddr = wa2_reg;
            ram_wdata = sum;
        end
    end

    fec_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_DELAY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= accept;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg  <= $signed({~adc_sample[SAMPLE_W-1], adc_sample[SAMPLE_W-2:0]});
            wa1_reg <= wr_pos;
        end
        if (load2)
        begin
            x2_reg    <= x1_reg;
            wa2_reg   <= wa1_reg;
            prod2_reg <= prod_next;
        end
        if (load3)
        begin
            dac_reg <= {dac_high, 1'b0};
        end
    end

    assign out_valid = v3_reg;
    assign dac_word  = dac_reg;

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("pipeline holds an item during store clearing");

    a_distinct_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> (wa1_reg != wa2_reg))
        else $error("adjacent in-flight items target the same store entry");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        load3 |=> v3_reg)
        else $error("store write-back without an output transfer pending");

endmodule

`default_nettype wire

>>> sv/feedback_echo_comb.sv
// Feedback comb echo: top level with configuration port, control and datapath.
//
// Input channel (in_valid/in_ready, adc_sample): one 10-bit converter sample per transfer.
// Output channel (out_valid/out_ready, dac_word): one 12-bit DAC code per input sample.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes the
// Q10 feedback gain, index 1 the ring length; other indexes are dropped. cfg_ready is
// always high; write only while no sample is in flight.
// Path: a sample transferred in is read from the store at the transfer edge, then
// multiplied in a registered stage, then summed, written back and registered at the output.
// Throughput: one sample per cycle for ring lengths of 4 and above when the receiver takes
// every word. A read that hits an entry still being computed holds in_ready low until the
// write-back, so a length of 3 runs below that rate and a length of 2 slower still.
// Reset: gain 502, length 1010, write position 0, then a clearing pass zeroes the
// MAX_DELAY-entry store, one entry a cycle, with in_ready low until the pass ends.
// Receiver stall: the output register holds its word; earlier stages keep filling until
// each is full, then in_ready drops. No sample is lost or repeated.
`default_nettype none

module feedback_echo_comb
    import fec_pkg::*;
#(
    parameter int MAX_DELAY = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_W-1:0]   adc_sample,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [DAC_W-1:0]      dac_word,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_DELAY);

    logic [GAIN_W-1:0] gain;
    logic [AW-1:0]     wr_pos;
    logic [AW-1:0]     rd_addr;
    logic              clr_busy;
    logic [AW-1:0]     clr_addr;
    logic              accept;

    assign cfg_ready = 1'b1;

    fec_ctrl #(
        .MAX_DELAY (MAX_DELAY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .gain      (gain),
        .wr_pos    (wr_pos),
        .rd_addr   (rd_addr),
        .clr_busy  (clr_busy),
        .clr_addr  (clr_addr)
    );

    fec_pipe #(
        .MAX_DELAY (MAX_DELAY)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dac_word   (dac_word),
        .gain       (gain),
        .wr_pos     (wr_pos),
        .rd_addr    (rd_addr),
        .clr_busy   (clr_busy),
        .clr_addr   (clr_addr),
        .accept     (accept)
    );

endmodule

`default_nettype wire

>>> tb/sv/feedback_echo_monitor.sv
// Channel monitor for the feedback echo comb: predicts each DAC word and compares transfers.
module feedback_echo_monitor
    import fec_pkg::*;
#(
    parameter int MAX_DELAY = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   adc_sample,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [DAC_W-1:0]      dac_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int MIDSCALE = 512;

    logic [GAIN_W-1:0]            fb_gain;
    logic [DLEN_W-1:0]            ring_setting;
    logic signed [STORE_W-1:0]    echo_mem [MAX_DELAY];
    int                           wr_pos;
    logic [DAC_W-1:0]             expected_dac_words [$];
    logic [DAC_W-1:0]             want;
    int                           samples_in;
    int                           words_out;

    assign pending = samples_in - words_out;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic [DAC_W-1:0] predict_dac_word(input logic [SAMPLE_W-1:0] s);
        int                 ring_len;
        int                 rd_pos;
        int                 x;
        int                 fb;
        logic [STORE_W-1:0] sum;
        logic [STORE_W-1:0] biased;
        ring_len = int'(ring_setting);
        if (ring_len < 2)
            ring_len = 2;
        if (ring_len > MAX_DELAY)
            ring_len = MAX_DELAY;
        if (wr_pos >= ring_len)
            wr_pos = 0;
        rd_pos = wr_pos + 1;
        if (rd_pos >= ring_len)
            rd_pos = 0;
        x = int'(s) - MIDSCALE;
        fb = (int'(fb_gain) * int'(echo_mem[rd_pos])) / (1 << FRAC_W);
        sum = STORE_W'(x + fb);
        echo_mem[wr_pos] = sum;
        wr_pos = wr_pos + 1;
        if (wr_pos >= ring_len)
            wr_pos = 0;
        biased = sum + STORE_W'(MIDSCALE);
        return {biased[DAC_W-2:0], 1'b0};
    endfunction

    initial
    begin
        errors = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_gain <= GAIN_RESET;
            ring_setting <= DLEN_RESET;
            for (int i = 0; i < MAX_DELAY; i++)
                echo_mem[i] = '0;
            wr_pos = 0;
            expected_dac_words.delete();
            samples_in <= 0;
            words_out <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FEEDBACK_GAIN)
                    fb_gain <= cfg_data[GAIN_W-1:0];
                else if (cfg_index == REG_DELAY_LENGTH)
                    ring_setting <= cfg_data[DLEN_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                expected_dac_words.push_back(predict_dac_word(adc_sample));
                samples_in <= samples_in + 1;
            end
            if (out_valid && out_ready)
            begin
                words_out <= words_out + 1;
                if (expected_dac_words.size() == 0)
                    report_mismatch($sformatf("dac_word %0d with no sample pending", dac_word));
                else
                begin
                    want = expected_dac_words.pop_front();
                    if (dac_word !== want)
                        report_mismatch($sformatf("dac_word %0d, expected %0d (transfer %0d)",
                                                  dac_word, want, words_out));
                end
            end
        end
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the feedback echo comb: clock, reset, stimulus, receiver stalls, verdict.
module tb
    import fec_pkg::*;
();

    localparam int MAX_DELAY = 1024;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX   = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   adc_sample;
    logic                  out_valid;
    logic                  out_ready;
    logic [DAC_W-1:0]      dac_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    bit                    burst_mode;
    bit                    stall_request;

    feedback_echo_comb #(.MAX_DELAY(MAX_DELAY)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dac_word   (dac_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    feedback_echo_monitor #(.MAX_DELAY(MAX_DELAY)) monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dac_word   (dac_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_200_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return prev;
        if (r == 4)
            return '0;
        if (r == 5)
            return SAMPLE_MAX;
        return SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX)));
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold until every predicted word has been transferred out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] gain_word,
                              input logic [CFG_DATA_W-1:0] length_word);
        wait_drained();
        write_reg(REG_FEEDBACK_GAIN, gain_word);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED_A, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED_B, CFG_DATA_W'($urandom));
        write_reg(REG_DELAY_LENGTH, length_word);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            int hold;
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (burst_mode)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0]   s;
        logic [CFG_DATA_W-1:0] gain_word;
        logic [CFG_DATA_W-1:0] length_word;
        int                    items;
        int                    r;
        burst_mode = 1'b0;
        stall_request = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        adc_sample <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FEEDBACK_GAIN;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes and alternating bit patterns
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(10'd512);
        send_sample(10'd511);
        send_sample(10'd513);
        send_sample(10'h155);
        send_sample(10'h2AA);
        send_sample(SAMPLE_MAX);

        // full gain on the shortest ring, gain word with its unused top bit set
        set_config(11'h7FF, 11'd2);
        send_sample('0);
        send_sample('0);
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        // length below the minimum, zero gain
        set_config(11'd0, 11'd0);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(10'd300);

        // length above the ring size
        set_config(11'd1, 11'h7FF);
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(10'd700);

        s = '0;
        for (int p = 0; p < 14; p++)
        begin
            items = 32;
            case (p)
                0:
                begin
                    gain_word = {1'b0, GAIN_RESET};
                    length_word = 11'd1024;
                    items = 50;
                end
                1:
                begin
                    // shorter ring leaves the write position past its end
                    gain_word = 11'd1023;
                    length_word = 11'd3;
                end
                2:
                begin
                    gain_word = 11'd1023;
                    length_word = 11'd2;
                    items = 140;
                end
                3:
                begin
                    gain_word = CFG_DATA_W'($urandom);
                    length_word = CFG_DATA_W'($urandom_range(4, 64));
                end
                4:
                begin
                    gain_word = 11'd1023;
                    length_word = 11'd4;
                end
                default:
                begin
                    r = $urandom_range(0, 4);
                    gain_word = (r == 0) ? 11'd0 : (r == 1) ? 11'd1023 :
                                (r == 2) ? {1'b0, GAIN_RESET} : CFG_DATA_W'($urandom);
                    gain_word[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
                    r = $urandom_range(0, 7);
                    case (r)
                        0: length_word = 11'd0;
                        1: length_word = 11'd1;
                        2: length_word = CFG_DATA_W'($urandom_range(2, 5));
                        3: length_word = 11'd1024;
                        4: length_word = CFG_DATA_W'($urandom_range(1025, 2047));
                        default: length_word = CFG_DATA_W'($urandom_range(6, 48));
                    endcase
                end
            endcase
            set_config(gain_word, length_word);
            burst_mode = (p == 4) || ($urandom_range(0, 5) == 0 && p > 4);
            if (p == 3)
                stall_request = 1'b1;
            for (int i = 0; i < items; i++)
            begin
                if (p == 2)
                    s = (i < items / 2) ? '0 : SAMPLE_MAX;
                else
                    s = pick_sample(s);
                send_sample(s);
            end
            burst_mode = 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/fec_pkg.sv
sv/fec_ram.sv
sv/fec_ctrl.sv
sv/fec_pipe.sv
sv/feedback_echo_comb.sv
tb/sv/feedback_echo_monitor.sv
tb/sv/tb.sv
